@@ hw/rtl/dpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared types, register indexes and small arithmetic helpers for the depth
// pixel colour mapper.
// ----------------------------------------------------------------------------
package dpcm_pkg;

  localparam int NUM_STAGES = 4;

  // configuration register indexes
  localparam logic REG_CHANNEL_COUNT  = 1'b0;
  localparam logic REG_DEPTH_MAP_MODE = 1'b1;

  // supported channel counts
  localparam logic [3:0] CH_MONO = 4'd1;
  localparam logic [3:0] CH_RGB  = 4'd3;
  localparam logic [3:0] CH_RGBA = 4'd4;

  // bytes_valid codes
  localparam logic [1:0] COUNT_NONE  = 2'd0;
  localparam logic [1:0] COUNT_ONE   = 2'd1;
  localparam logic [1:0] COUNT_THREE = 2'd3;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_load_t;

  // side-band data that travels with each pixel
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic       err;
    logic       is_depth;
  } side_t;

  // floor(w / 200) for w < 51200: floor(floor(w/8)/25) by reciprocal multiply
  function automatic logic [7:0] div200(input logic [15:0] w);
    logic [25:0] p;
    p = {13'd0, w[15:3]} * 26'd5243;
    return p[24:17];
  endfunction

  // x mod 6 for an 8-bit x
  function automatic logic [2:0] mod6(input logic [7:0] x);
    logic [15:0] p;
    logic [5:0]  q;
    logic [7:0]  rem;
    p   = {8'd0, x} * 16'd171;
    q   = p[15:10];
    rem = x - ({2'd0, q} * 8'd6);
    return rem[2:0];
  endfunction

endpackage

@@ hw/rtl/depth_pixel_colour_mapper.sv @@
// Pipeline: four register stages; out_valid rises once an accepted pixel
// reaches the stage 4 output register, where the result can be taken.
// Throughput: one pixel per cycle unless out_ready stalls; no state links pixels.
// The depth path holds one multiplier stage and three constant divides by 200.
// Reset clears all stage valid bits; channel_count resets to 3 and
// depth_map_mode to 0.
// ----------------------------------------------------------------------------
// depth_pixel_colour_mapper
// Per-pixel byte mapper: pass-through for one and three channels, alpha copy
// or depth-to-colour-cone mapping for four channels; other counts flag an error.
// ----------------------------------------------------------------------------
module depth_pixel_colour_mapper
  import dpcm_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        pixel_bytes,
  input  logic signed [23:0] depth_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         first_byte,
  output logic [7:0]         second_byte,
  output logic [7:0]         third_byte,
  output logic [1:0]         bytes_valid,
  output logic               channel_error
);

  logic [3:0] channel_count;
  logic       depth_map_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= CH_RGB;
      depth_map_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:  channel_count  <= cfg_data;
        REG_DEPTH_MAP_MODE: depth_map_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  stage_load_t                 load;
  side_t                       side1;
  side_t                       side3;
  logic [8+FRAC_BITS-1:0]      reach;
  logic [FRAC_BITS-1:0]        frac;
  logic [7:0]                  int_part;
  logic [2:0]                  sector;
  logic [7:0]                  val;
  logic [15:0]                 rise_w;
  logic [15:0]                 fall_w;

  dpcm_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .load      (load)
  );

  dpcm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .load           (load.s1),
    .channel_count  (channel_count),
    .depth_map_mode (depth_map_mode),
    .pixel_bytes    (pixel_bytes),
    .depth_value    (depth_value),
    .side           (side1),
    .reach          (reach),
    .frac           (frac),
    .int_part       (int_part)
  );

  dpcm_cone #(.FRAC_BITS(FRAC_BITS)) u_cone (
    .clk      (clk),
    .load_s2  (load.s2),
    .load_s3  (load.s3),
    .side_in  (side1),
    .reach    (reach),
    .frac     (frac),
    .int_part (int_part),
    .side_out (side3),
    .sector   (sector),
    .val      (val),
    .rise_w   (rise_w),
    .fall_w   (fall_w)
  );

  dpcm_out u_out (
    .clk           (clk),
    .load          (load.s4),
    .side          (side3),
    .sector        (sector),
    .val           (val),
    .rise_w        (rise_w),
    .fall_w        (fall_w),
    .first_byte    (first_byte),
    .second_byte   (second_byte),
    .third_byte    (third_byte),
    .bytes_valid   (bytes_valid),
    .channel_error (channel_error)
  );

  // an error result carries no bytes
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_error |->
      (bytes_valid == COUNT_NONE) && (first_byte == 8'd0) &&
      (second_byte == 8'd0) && (third_byte == 8'd0))
    else $error("error transaction carries data");

  // single-channel results leave the upper bytes clear
  a_mono_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bytes_valid == COUNT_ONE) |->
      (second_byte == 8'd0) && (third_byte == 8'd0) && !channel_error)
    else $error("single-channel transaction with stray bytes");

endmodule

@@ hw/rtl/dpcm_flow.sv @@
// ----------------------------------------------------------------------------
// dpcm_flow
// Valid bits and per-stage load enables for the four-stage pipeline.
// ----------------------------------------------------------------------------
module dpcm_flow
  import dpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output stage_load_t load
);

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_ready;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    stage_ready[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) stage_valid[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_ready[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[NUM_STAGES-1];
  assign load.s1   = stage_ready[0];
  assign load.s2   = stage_ready[1];
  assign load.s3   = stage_ready[2];
  assign load.s4   = stage_ready[3];

  // back-pressure only when every stage holds a transaction
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&stage_valid))
    else $error("input blocked while a stage is empty");

  // transactions in flight change only by accepts on either side
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(stage_valid) == $past($countones(stage_valid))
      + $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready))))
    else $error("transaction lost or duplicated in pipeline");

  // a waiting output transaction is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled output transaction dropped");

endmodule

@@ hw/rtl/dpcm_front.sv @@
// ----------------------------------------------------------------------------
// dpcm_front
// Stage 1: channel decode, pass-through bytes, depth range check and the
// distance to the far limit.
// ----------------------------------------------------------------------------
module dpcm_front
  import dpcm_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [3:0]                channel_count,
  input  logic                      depth_map_mode,
  input  logic [31:0]               pixel_bytes,
  input  logic signed [23:0]        depth_value,
  output side_t                     side,
  output logic [8+FRAC_BITS-1:0]    reach,
  output logic [FRAC_BITS-1:0]      frac,
  output logic [7:0]                int_part
);

  localparam int EW = 8 + FRAC_BITS;
  localparam int CW = (EW > 23) ? EW : 23;
  localparam logic [CW-1:0] DEPTH_MAX = CW'(200) << FRAC_BITS;

  side_t             side_next;
  logic [CW-1:0]     mag;
  logic              in_range;
  logic [EW-1:0]     reach_next;

  assign mag      = CW'(depth_value[22:0]);
  // negative or at or beyond the far limit gives a zero value, hence black
  assign in_range = !depth_value[23] && (mag < DEPTH_MAX);
  assign reach_next = in_range ? EW'(DEPTH_MAX - mag) : '0;

  always_comb begin
    side_next = '0;
    case (channel_count)
      CH_RGBA: begin
        side_next.count = COUNT_THREE;
        if (depth_map_mode) begin
          side_next.is_depth = 1'b1;
        end else begin
          side_next.b0 = pixel_bytes[31:24];
          side_next.b1 = pixel_bytes[31:24];
          side_next.b2 = pixel_bytes[31:24];
        end
      end
      CH_RGB: begin
        side_next.count = COUNT_THREE;
        side_next.b0    = pixel_bytes[7:0];
        side_next.b1    = pixel_bytes[15:8];
        side_next.b2    = pixel_bytes[23:16];
      end
      CH_MONO: begin
        side_next.count = COUNT_ONE;
        side_next.b0    = pixel_bytes[7:0];
      end
      default: begin
        side_next.err   = 1'b1;
        side_next.count = COUNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side     <= side_next;
      reach    <= reach_next;
      frac     <= depth_value[FRAC_BITS-1:0];
      int_part <= 8'(mag >> FRAC_BITS);
    end
  end

endmodule

@@ hw/rtl/dpcm_cone.sv @@
// ----------------------------------------------------------------------------
// dpcm_cone
// Stages 2 and 3: products for the cone value and the two ramps, scaling by
// 255 and removal of fraction bits, value divide and hue sector.
// ----------------------------------------------------------------------------
module dpcm_cone
  import dpcm_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      load_s2,
  input  logic                      load_s3,
  input  side_t                     side_in,
  input  logic [8+FRAC_BITS-1:0]    reach,
  input  logic [FRAC_BITS-1:0]      frac,
  input  logic [7:0]                int_part,
  output side_t                     side_out,
  output logic [2:0]                sector,
  output logic [7:0]                val,
  output logic [15:0]               rise_w,
  output logic [15:0]               fall_w
);

  localparam int EW = 8 + FRAC_BITS;
  localparam int PW = EW + FRAC_BITS + 1;

  // stage 2
  side_t              side2;
  logic [2:0]         sector2;
  logic [PW-1:0]      prod_rise;
  logic [PW-1:0]      prod_fall;
  logic [15:0]        val_w;
  logic [EW+7:0]      reach_x255;
  logic [FRAC_BITS:0] frac_inv;

  assign reach_x255 = {reach, 8'd0} - {8'd0, reach};
  assign frac_inv   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};

  always_ff @(posedge clk) begin
    if (load_s2) begin
      side2     <= side_in;
      sector2   <= mod6(int_part);
      prod_rise <= PW'(reach) * PW'(frac);
      prod_fall <= PW'(reach) * PW'(frac_inv);
      val_w     <= 16'(reach_x255 >> FRAC_BITS);
    end
  end

  // stage 3
  logic [PW+7:0] rise_x255;
  logic [PW+7:0] fall_x255;

  assign rise_x255 = {prod_rise, 8'd0} - {8'd0, prod_rise};
  assign fall_x255 = {prod_fall, 8'd0} - {8'd0, prod_fall};

  always_ff @(posedge clk) begin
    if (load_s3) begin
      side_out <= side2;
      sector   <= sector2;
      val      <= div200(val_w);
      rise_w   <= 16'(rise_x255 >> (2 * FRAC_BITS));
      fall_w   <= 16'(fall_x255 >> (2 * FRAC_BITS));
    end
  end

endmodule

@@ hw/rtl/dpcm_out.sv @@
// ----------------------------------------------------------------------------
// dpcm_out
// Stage 4: ramp divides, sector selection and the output register.
// ----------------------------------------------------------------------------
module dpcm_out
  import dpcm_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  side_t       side,
  input  logic [2:0]  sector,
  input  logic [7:0]  val,
  input  logic [15:0] rise_w,
  input  logic [15:0] fall_w,
  output logic [7:0]  first_byte,
  output logic [7:0]  second_byte,
  output logic [7:0]  third_byte,
  output logic [1:0]  bytes_valid,
  output logic        channel_error
);

  logic [7:0] rise;
  logic [7:0] fall;
  logic [7:0] b0_next;
  logic [7:0] b1_next;
  logic [7:0] b2_next;

  assign rise = div200(rise_w);
  assign fall = div200(fall_w);

  always_comb begin
    b0_next = side.b0;
    b1_next = side.b1;
    b2_next = side.b2;
    if (side.is_depth) begin
      case (sector)
        3'd0: begin b0_next = val;  b1_next = rise; b2_next = 8'd0; end
        3'd1: begin b0_next = fall; b1_next = val;  b2_next = 8'd0; end
        3'd2: begin b0_next = 8'd0; b1_next = val;  b2_next = rise; end
        3'd3: begin b0_next = 8'd0; b1_next = fall; b2_next = val;  end
        3'd4: begin b0_next = rise; b1_next = 8'd0; b2_next = val;  end
        default: begin b0_next = val; b1_next = 8'd0; b2_next = fall; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_byte    <= b0_next;
      second_byte   <= b1_next;
      third_byte    <= b2_next;
      bytes_valid   <= side.count;
      channel_error <= side.err;
    end
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the depth pixel colour mapper: drives pixels under
// a range of channel_count / depth_map_mode settings, predicts each output
// pixel in a scoreboard and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module testbench
  import dpcm_pkg::*;
();

  localparam int FRAC_BITS   = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_ITEMS   = 52;
  localparam int STALL_LEN   = 300;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic       err;
  } pixel_out_t;

  class pixel_scoreboard;
    logic [3:0]  chan_count;
    logic        depth_mode;
    pixel_out_t  expected_pixels[$];
    int          errors;

    function new();
      chan_count = CH_RGB;
      depth_mode = 1'b0;
      errors     = 0;
    endfunction

    function void set_config(logic [3:0] cc, logic mode);
      chan_count = cc;
      depth_mode = mode;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // HSV cone, full saturation, exact integer math truncated toward zero
    function void cone_rgb(logic [23:0] raw, output logic [7:0] c0,
                           output logic [7:0] c1, output logic [7:0] c2);
      longint unsigned one, span, f, num, r, v, t, q, sector;
      c0 = 8'd0;
      c1 = 8'd0;
      c2 = 8'd0;
      if (raw[23]) return;
      one    = 64'd1 << FRAC_BITS;
      span   = 64'd200 << FRAC_BITS;
      f      = {40'd0, raw};
      num    = (f >= span) ? 64'd0 : 64'd255 * (span - f);
      r      = f & (one - 64'd1);
      sector = (f >> FRAC_BITS) % 64'd6;
      v      = num / span;
      t      = (num * r) / (span * one);
      q      = (num * (one - r)) / (span * one);
      case (sector)
        64'd0: begin c0 = v[7:0]; c1 = t[7:0]; end
        64'd1: begin c0 = q[7:0]; c1 = v[7:0]; end
        64'd2: begin c1 = v[7:0]; c2 = t[7:0]; end
        64'd3: begin c1 = q[7:0]; c2 = v[7:0]; end
        64'd4: begin c0 = t[7:0]; c2 = v[7:0]; end
        default: begin c0 = v[7:0]; c2 = q[7:0]; end
      endcase
    endfunction

    function void note_pixel(logic [31:0] px, logic [23:0] dv);
      pixel_out_t want;
      want = '0;
      if (chan_count == CH_RGBA) begin
        if (depth_mode) begin
          cone_rgb(dv, want.b0, want.b1, want.b2);
        end else begin
          want.b0 = px[31:24];
          want.b1 = px[31:24];
          want.b2 = px[31:24];
        end
        want.count = COUNT_THREE;
      end else if (chan_count == CH_RGB) begin
        want.b0    = px[7:0];
        want.b1    = px[15:8];
        want.b2    = px[23:16];
        want.count = COUNT_THREE;
      end else if (chan_count == CH_MONO) begin
        want.b0    = px[7:0];
        want.count = COUNT_ONE;
      end else begin
        want.count = COUNT_NONE;
        want.err   = 1'b1;
      end
      expected_pixels.push_back(want);
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output pixel: b0=%h b1=%h b2=%h count=%0d err=%b",
                   got.b0, got.b1, got.b2, got.count, got.err);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.b0 !== want.b0 || got.b1 !== want.b1 || got.b2 !== want.b2 ||
          got.count !== want.count || got.err !== want.err) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch (cc=%0d dm=%b): exp %h %h %h %0d %b, got %h %h %h %0d %b",
                   chan_count, depth_mode, want.b0, want.b1, want.b2, want.count,
                   want.err, got.b0, got.b1, got.b2, got.count, got.err);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [3:0]         cfg_data = 4'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        pixel_bytes = 32'd0;
  logic signed [23:0] depth_value = 24'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         first_byte;
  logic [7:0]         second_byte;
  logic [7:0]         third_byte;
  logic [1:0]         bytes_valid;
  logic               channel_error;

  pixel_scoreboard sb = new();

  int  idle_mode = 2;       // 0: receiver mostly stalls, 1: sender mostly idles, 2: none
  int  sender_idle_pct = 0;
  bit  stall_kick = 1'b0;
  bit  stall_seen = 1'b0;
  int  stall_left = 0;
  int  cycle_count = 0;

  depth_pixel_colour_mapper #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_bytes(pixel_bytes), .depth_value(depth_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .first_byte(first_byte), .second_byte(second_byte), .third_byte(third_byte),
    .bytes_valid(bytes_valid), .channel_error(channel_error)
  );

  always #6 clk = ~clk;

  // output side backpressure, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= STALL_LEN;
      out_ready  <= 1'b0;
    end else begin
      case (idle_mode)
        0: out_ready <= ($urandom_range(99) >= 85);
        1: out_ready <= ($urandom_range(99) >= 15);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    pixel_out_t got;
    if (!rst && out_valid && out_ready) begin
      got.b0    = first_byte;
      got.b1    = second_byte;
      got.b2    = third_byte;
      got.count = bytes_valid;
      got.err   = channel_error;
      sb.check_pixel(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [31:0] px, input logic [23:0] dv);
    int gaps;
    gaps = 0;
    while (gaps < 30 && $urandom_range(99) < sender_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_bytes <= px;
    depth_value <= dv;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px, dv);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] cc, input logic mode);
    in_valid <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= cc;
    @(posedge clk);
    cfg_index <= REG_DEPTH_MAP_MODE;
    cfg_data  <= {3'd0, mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(cc, mode);
  endtask

  function automatic logic [23:0] pick_depth(bit depth_cfg);
    int sel;
    logic [23:0] d;
    d = 24'($urandom);
    if (!depth_cfg) return d;
    sel = $urandom_range(99);
    if (sel < 55)
      d = 24'($urandom_range((200 << FRAC_BITS) - 1));
    else if (sel < 70)
      d = 24'(($urandom_range(199) << FRAC_BITS) +
              ($urandom_range(1) ? $urandom_range(3) :
                                   (1 << FRAC_BITS) - 1 - $urandom_range(3)));
    else if (sel < 80)
      d[23] = 1'b1;
    return d;
  endfunction

  task automatic run_segment(input int n, input bit depth_cfg);
    for (int i = 0; i < n; i++) send_pixel($urandom, pick_depth(depth_cfg));
  endtask

  logic [3:0] seg_cc[8]   = '{CH_RGB, CH_MONO, CH_RGBA, CH_RGBA, 4'd0, 4'd15, CH_MONO, 4'd0};
  logic       seg_mode[8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

  initial begin
    logic [3:0] cc;
    logic       mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: pass-through extremes
    apply_config(CH_RGB, 1'b0);
    send_pixel(32'h0000_0000, 24'h000000);
    send_pixel(32'hFFFF_FFFF, 24'hFFFFFF);
    send_pixel(32'h00A5_5A3C, 24'h800000);
    apply_config(CH_MONO, 1'b0);
    send_pixel(32'hFFFF_FFFF, 24'h7FFFFF);
    send_pixel(32'h1234_5678, 24'h000000);
    apply_config(CH_RGBA, 1'b0);
    send_pixel(32'hFF00_0000, 24'h000000);
    send_pixel(32'h00FF_FFFF, 24'hFFFFFF);

    // depth map: zero, each sector, wrap of the sector count, 200 and beyond, negative
    apply_config(CH_RGBA, 1'b1);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    send_pixel(32'h0000_0000, 24'((1 << FRAC_BITS) - 1));
    for (int k = 0; k < 7; k++)
      send_pixel($urandom, 24'((k << FRAC_BITS) + (1 << (FRAC_BITS - 1))));
    send_pixel($urandom, 24'((200 << FRAC_BITS) - 1));
    send_pixel($urandom, 24'(200 << FRAC_BITS));
    send_pixel($urandom, 24'h7FFFFF);
    send_pixel($urandom, 24'h800000);
    send_pixel($urandom, 24'hFFFFFF);

    // unsupported counts, and depth mode ignored for three channels
    apply_config(4'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 24'hFFFFFF);
    apply_config(4'd15, 1'b1);
    send_pixel(32'hFFFF_FFFF, 24'h123456);
    apply_config(CH_RGB, 1'b1);
    send_pixel(32'hC3C3_C3C3, 24'h001000);

    for (int m = 0; m < 3; m++) begin
      idle_mode       <= m;
      sender_idle_pct = (m == 0) ? 15 : (m == 1) ? 85 : 0;
      for (int c = 0; c < 8; c++) begin
        cc   = seg_cc[c];
        mode = seg_mode[c];
        if (c == 7) begin
          cc   = $urandom_range(1) ? CH_RGBA : 4'($urandom_range(15));
          mode = 1'($urandom_range(1));
        end
        apply_config(cc, mode);
        // long receiver hold-off while pixels keep coming
        if (m == 2 && c == 3) stall_kick <= ~stall_kick;
        run_segment(SEG_ITEMS, cc == CH_RGBA && mode);
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (4 * NUM_STAGES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dpcm_pkg.sv
hw/rtl/dpcm_flow.sv
hw/rtl/dpcm_front.sv
hw/rtl/dpcm_cone.sv
hw/rtl/dpcm_out.sv
hw/rtl/depth_pixel_colour_mapper.sv
dv/testbench.sv
